// ===== rtl/core/wrf_pkg.sv =====
// Shared widths, request codes and types of the word ring FIFO.
package wrf_pkg;

    localparam int DATA_W  = 32;
    localparam int LEN_W   = 5;
    localparam int COUNT_W = 9;

    typedef logic [1:0] t_req;

    localparam t_req REQ_WRITE = 2'd0;
    localparam t_req REQ_READ  = 2'd1;
    localparam t_req REQ_PEEK  = 2'd2;
    localparam t_req REQ_CLEAR = 2'd3;

    typedef logic [DATA_W-1:0]  t_word;
    typedef logic [LEN_W-1:0]   t_len;
    typedef logic [COUNT_W-1:0] t_count;

endpackage

// ===== rtl/core/word_ring_fifo_burst.sv =====
// Top level of the word ring FIFO with burst-checked writes.
//
// Input channel: i_valid / o_stall carry one request (write word, read burst,
// peek burst or clear). Output channel: o_valid / i_stall carry result words.
// A write word, a clear and any rejected request give one result, loaded into
// the output register at the edge that accepts the request. A read or peek of
// n words gives n results: the store reads the first word at the accepting
// edge, and it moves from the store read register to the output register;
// then one word per cycle barring a receiver stall, limited by the single
// store read port. No request is taken until a burst's last word is in the
// output register; writes and clears sustain one request per cycle barring a
// stall. used_count and free_count on every result give the state after the
// whole request. When the receiver stalls, the output word holds and the
// store read waits; the request side stalls until the output register can
// take a result. Reset empties the FIFO and ends any open write burst; the
// word store itself is not cleared, and only written entries are ever read.
module word_ring_fifo_burst #(
    parameter int DEPTH     = 256,
    parameter int MAX_BURST = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  wrf_pkg::t_req       i_req_type,
    input  wrf_pkg::t_word      i_wr_data,
    input  wrf_pkg::t_len       i_burst_len,
    input  logic                i_burst_first,
    output logic                o_valid,
    input  logic                i_stall,
    output wrf_pkg::t_word      o_rd_data,
    output logic                o_status,
    output logic                o_last,
    output wrf_pkg::t_count     o_used_count,
    output wrf_pkg::t_count     o_free_count
);
    import wrf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OW = $clog2(DEPTH + 1);
    localparam int XW = OW + COUNT_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RD   = 1'b1;

    function automatic logic [AW-1:0] f_wrap(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic          r_state, n_state;
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [AW-1:0] r_raddr, n_raddr;
    logic [OW-1:0] r_occ, n_occ;
    t_len          r_left, n_left;
    logic          r_rej, n_rej;
    t_len          r_iss, n_iss;
    t_len          r_rem, n_rem;
    logic          r_pend, n_pend;
    logic          r_out_valid, n_out_valid;
    t_word         r_out_data, n_out_data;
    logic          r_out_status, n_out_status;
    logic          r_out_last, n_out_last;

    logic          out_free;
    logic          accept;
    logic          len_bad;
    logic [OW-1:0] free_w;
    logic [XW-1:0] rsum;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    t_word         mem_rdata;
    logic          st;
    logic          do_store;

    wrf_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wptr),
        .i_wdata (i_wr_data),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = !((r_state == ST_IDLE) && out_free);
    assign accept   = i_valid && !o_stall;
    assign free_w   = OW'(DEPTH) - r_occ;
    assign len_bad  = (i_burst_len == '0) || (7'(i_burst_len) > 7'(MAX_BURST));

    always_comb begin
        n_state      = r_state;
        n_wptr       = r_wptr;
        n_rptr       = r_rptr;
        n_raddr      = r_raddr;
        n_occ        = r_occ;
        n_left       = r_left;
        n_rej        = r_rej;
        n_iss        = r_iss;
        n_rem        = r_rem;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_raddr    = r_raddr;
        st           = 1'b1;
        do_store     = 1'b0;
        rsum         = XW'(r_rptr) + XW'(i_burst_len);
        if (rsum >= XW'(DEPTH)) begin
            rsum = rsum - XW'(DEPTH);
        end

        if (out_free) begin
            n_out_valid = 1'b0;
        end

        if (accept) begin
            case (i_req_type)
                REQ_WRITE: begin
                    if (i_burst_first) begin
                        n_left = '0;
                        n_rej  = 1'b0;
                        if (len_bad) begin
                            st = 1'b1;
                        end else if (XW'(i_burst_len) > XW'(free_w)) begin
                            n_left = i_burst_len - 1'b1;
                            n_rej  = 1'b1;
                            st     = 1'b1;
                        end else begin
                            n_left   = i_burst_len - 1'b1;
                            do_store = 1'b1;
                            st       = 1'b0;
                        end
                    end else if (r_left == '0) begin
                        st = 1'b1;
                    end else begin
                        n_left = r_left - 1'b1;
                        if (r_rej) begin
                            st = 1'b1;
                        end else begin
                            do_store = 1'b1;
                            st       = 1'b0;
                        end
                        if (r_left == LEN_W'(1)) begin
                            n_rej = 1'b0;
                        end
                    end
                    if (do_store && (r_occ < OW'(DEPTH))) begin
                        mem_we = 1'b1;
                        n_wptr = f_wrap(r_wptr);
                        n_occ  = r_occ + 1'b1;
                    end
                    n_out_valid  = 1'b1;
                    n_out_data   = '0;
                    n_out_status = st;
                    n_out_last   = 1'b1;
                end
                REQ_CLEAR: begin
                    n_wptr       = '0;
                    n_rptr       = '0;
                    n_occ        = '0;
                    n_left       = '0;
                    n_rej        = 1'b0;
                    n_out_valid  = 1'b1;
                    n_out_data   = '0;
                    n_out_status = 1'b0;
                    n_out_last   = 1'b1;
                end
                default: begin
                    if (len_bad || (XW'(i_burst_len) > XW'(r_occ))) begin
                        n_out_valid  = 1'b1;
                        n_out_data   = '0;
                        n_out_status = 1'b1;
                        n_out_last   = 1'b1;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = r_rptr;
                        n_raddr   = f_wrap(r_rptr);
                        n_iss     = i_burst_len - 1'b1;
                        n_rem     = i_burst_len;
                        n_pend    = 1'b1;
                        n_state   = ST_RD;
                        if (i_req_type == REQ_READ) begin
                            n_rptr = AW'(rsum);
                            n_occ  = r_occ - OW'(i_burst_len);
                        end
                    end
                end
            endcase
        end

        if (r_state == ST_RD) begin
            if (r_pend && out_free) begin
                n_out_valid  = 1'b1;
                n_out_data   = mem_rdata;
                n_out_status = 1'b0;
                n_out_last   = (r_rem == LEN_W'(1));
                n_rem        = r_rem - 1'b1;
                n_pend       = 1'b0;
                if (r_rem == LEN_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            if ((r_iss != '0) && (!r_pend || out_free)) begin
                mem_re    = 1'b1;
                mem_raddr = r_raddr;
                n_raddr   = f_wrap(r_raddr);
                n_iss     = r_iss - 1'b1;
                n_pend    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_raddr     <= '0;
            r_occ       <= '0;
            r_left      <= '0;
            r_rej       <= 1'b0;
            r_iss       <= '0;
            r_rem       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wptr      <= n_wptr;
            r_rptr      <= n_rptr;
            r_raddr     <= n_raddr;
            r_occ       <= n_occ;
            r_left      <= n_left;
            r_rej       <= n_rej;
            r_iss       <= n_iss;
            r_rem       <= n_rem;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign o_valid      = r_out_valid;
    assign o_rd_data    = r_out_data;
    assign o_status     = r_out_status;
    assign o_last       = r_out_last;
    assign o_used_count = COUNT_W'(XW'(r_occ));
    assign o_free_count = COUNT_W'(XW'(free_w));

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OW'(DEPTH))
        else $error("occupancy above depth");

    a_no_take_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD) |-> o_stall)
        else $error("request taken during read burst");

    a_pend_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == ST_RD) && (r_rem != '0))
        else $error("store word pending outside read burst");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_rd_data == '0) && o_last)
        else $error("rejected result carries data or is not last");

    a_burst_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RD) && r_pend && out_free && (r_rem == LEN_W'(1)))
            |=> (r_state == ST_IDLE) && o_last)
        else $error("read burst did not end on its final word");
`endif

endmodule

// ===== rtl/core/wrf_store.sv =====
// Word store: one write port, one read port with registered read data.
module wrf_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  wrf_pkg::t_word      i_wdata,
    input  logic                i_re,
    input  logic [AW-1:0]       i_raddr,
    output wrf_pkg::t_word      o_rdata
);
    import wrf_pkg::*;

    t_word r_mem [DEPTH];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== test/word_ring_fifo_burst_test.sv =====
// Self-checking testbench of the word ring FIFO with burst-checked writes.
module word_ring_fifo_burst_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wrf_pkg::*;

    localparam int FIFO_DEPTH = 256;
    localparam int BURST_MAX  = 16;

    typedef struct packed {
        t_word  rd_data;
        logic   status;
        logic   last;
        t_count used_cnt;
        t_count free_cnt;
    } t_fifo_result;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_stall;
    t_req   i_req_type;
    t_word  i_wr_data;
    t_len   i_burst_len;
    logic   i_burst_first;
    logic   o_valid;
    logic   i_stall;
    t_word  o_rd_data;
    logic   o_status;
    logic   o_last;
    t_count o_used_count;
    t_count o_free_count;

    // mirror of the FIFO
    t_word      fifo_mem [FIFO_DEPTH];
    logic [7:0] wr_idx;
    logic [7:0] rd_idx;
    int         fill;
    int         burst_remaining;
    logic       burst_dropped;

    t_fifo_result fifo_results_q [$];
    t_fifo_result want;
    int           mismatches;
    int           req_count;
    int           tx_max;
    int           rx_max;
    int           rx_hold;

    word_ring_fifo_burst #(
        .DEPTH     (FIFO_DEPTH),
        .MAX_BURST (BURST_MAX)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_wr_data     (i_wr_data),
        .i_burst_len   (i_burst_len),
        .i_burst_first (i_burst_first),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_rd_data     (o_rd_data),
        .o_status      (o_status),
        .o_last        (o_last),
        .o_used_count  (o_used_count),
        .o_free_count  (o_free_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic void push_fifo_result(t_word data, logic st, logic lst);
        t_fifo_result r;
        r.rd_data  = data;
        r.status   = st;
        r.last     = lst;
        r.used_cnt = t_count'(fill);
        r.free_cnt = t_count'(FIFO_DEPTH - fill);
        fifo_results_q.push_back(r);
    endfunction

    function automatic void predict_request(t_req req, t_word data, t_len len, logic first);
        t_word words [BURST_MAX];
        logic  st;
        int    n;
        n = int'(len);
        if (req == REQ_WRITE) begin
            st = 1'b1;
            if (first) begin
                burst_remaining = 0;
                burst_dropped   = 1'b0;
                if (n == 0 || n > BURST_MAX) begin
                    st = 1'b1;
                end else if (n > FIFO_DEPTH - fill) begin
                    burst_remaining = n - 1;
                    burst_dropped   = 1'b1;
                end else begin
                    burst_remaining = n - 1;
                    st = 1'b0;
                end
            end else if (burst_remaining != 0) begin
                burst_remaining--;
                st = burst_dropped;
                if (burst_remaining == 0)
                    burst_dropped = 1'b0;
            end
            if (!st && fill < FIFO_DEPTH) begin
                fifo_mem[wr_idx] = data;
                wr_idx++;
                fill++;
            end
            push_fifo_result('0, st, 1'b1);
        end else if (req == REQ_CLEAR) begin
            wr_idx          = '0;
            rd_idx          = '0;
            fill            = 0;
            burst_remaining = 0;
            burst_dropped   = 1'b0;
            push_fifo_result('0, 1'b0, 1'b1);
        end else if (n == 0 || n > BURST_MAX || n > fill) begin
            push_fifo_result('0, 1'b1, 1'b1);
        end else begin
            for (int i = 0; i < n; i++)
                words[i] = fifo_mem[8'(rd_idx + i)];
            if (req == REQ_READ) begin
                rd_idx = 8'(rd_idx + n);
                fill   = fill - n;
            end
            for (int i = 0; i < n; i++)
                push_fifo_result(words[i], 1'b0, i == n - 1);
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (fifo_results_q.size() == 0) begin
                $error("result with nothing pending: rd_data %h status %b", o_rd_data, o_status);
                mismatches++;
            end else begin
                want = fifo_results_q.pop_front();
                if (o_rd_data !== want.rd_data) begin
                    $error("rd_data: expected %h, got %h", want.rd_data, o_rd_data);
                    mismatches++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %b, got %b", want.status, o_status);
                    mismatches++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, o_last);
                    mismatches++;
                end
                if (o_used_count !== want.used_cnt) begin
                    $error("used_count: expected %0d, got %0d", want.used_cnt, o_used_count);
                    mismatches++;
                end
                if (o_free_count !== want.free_cnt) begin
                    $error("free_count: expected %0d, got %0d", want.free_cnt, o_free_count);
                    mismatches++;
                end
            end
        end
    end

    // result side stall; a long hold-off is counted here
    initial begin : result_sink
        int gap;
        i_stall = 1'b0;
        forever begin
            if (rx_hold > 0)
                gap = rx_hold;
            else
                gap = (rx_max == 0) ? 0 : $urandom_range(rx_max, 0);
            rx_hold = 0;
            if (gap > 0) begin
                @(negedge i_clk) i_stall <= 1'b1;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk) i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
        end
    end

    task automatic send_req(t_req req, t_word data, t_len len, logic first);
        int gap;
        gap = (tx_max == 0) ? 0 : $urandom_range(tx_max, 0);
        if (gap > 0) begin
            @(negedge i_clk) i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_req_type    <= req;
        i_wr_data     <= data;
        i_burst_len   <= len;
        i_burst_first <= first;
        do @(posedge i_clk); while (o_stall);
        predict_request(req, data, len, first);
        req_count++;
    endtask

    task automatic wait_drain();
        @(negedge i_clk) i_valid <= 1'b0;
        while (fifo_results_q.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    function automatic t_len pick_read_len();
        if (fill > 0 && $urandom_range(4, 0) != 0)
            return t_len'($urandom_range((fill < BURST_MAX) ? fill : BURST_MAX, 1));
        return t_len'($urandom_range(31, 0));
    endfunction

    task automatic send_random_read();
        send_req(($urandom_range(1, 0) != 0) ? REQ_READ : REQ_PEEK, $urandom(),
                 pick_read_len(), 1'($urandom()));
    endtask

    task automatic test_empty_fifo();
        send_req(REQ_READ, 32'h0, 5'd1, 1'b0);
        send_req(REQ_PEEK, 32'hFFFF_FFFF, 5'd16, 1'b1);
    endtask

    task automatic test_write_bursts();
        send_req(REQ_WRITE, 32'h0000_0000, 5'd1, 1'b1);
        send_req(REQ_WRITE, 32'hFFFF_FFFF, 5'd3, 1'b1);
        send_req(REQ_WRITE, 32'hA5A5_A5A5, 5'd0, 1'b0);
        send_req(REQ_WRITE, 32'h5A5A_5A5A, 5'd31, 1'b0);
        // stray word outside a burst
        send_req(REQ_WRITE, 32'h1234_5678, 5'd2, 1'b0);
        // bad lengths on a first word
        send_req(REQ_WRITE, 32'h1111_1111, 5'd0, 1'b1);
        send_req(REQ_WRITE, 32'h2222_2222, 5'd17, 1'b1);
        send_req(REQ_WRITE, 32'h3333_3333, 5'd31, 1'b1);
        // read between words, then a new burst abandons the open one
        send_req(REQ_WRITE, 32'h4444_4444, 5'd4, 1'b1);
        send_req(REQ_WRITE, 32'h5555_5555, 5'd0, 1'b0);
        send_req(REQ_READ, 32'h0, 5'd1, 1'b0);
        send_req(REQ_WRITE, 32'h6666_6666, 5'd2, 1'b1);
        send_req(REQ_WRITE, 32'h7777_7777, 5'd0, 1'b0);
        // clear ends the open burst
        send_req(REQ_WRITE, 32'h8888_8888, 5'd3, 1'b1);
        send_req(REQ_CLEAR, 32'hFFFF_FFFF, 5'd31, 1'b1);
        send_req(REQ_WRITE, 32'h9999_9999, 5'd0, 1'b0);
    endtask

    task automatic test_read_peek();
        send_req(REQ_WRITE, 32'hDEAD_BEEF, 5'd2, 1'b1);
        send_req(REQ_WRITE, 32'hCAFE_F00D, 5'd0, 1'b0);
        send_req(REQ_PEEK, 32'h0, 5'd2, 1'b0);
        send_req(REQ_READ, 32'h0, 5'd3, 1'b0);
        send_req(REQ_READ, 32'h0, 5'd2, 1'b1);
        send_req(REQ_READ, 32'h0, 5'd17, 1'b0);
        send_req(REQ_PEEK, 32'h0, 5'd0, 1'b0);
    endtask

    task automatic test_fill_backpressure();
        wait_drain();
        tx_max = 0;
        rx_max = 0;
        send_req(REQ_CLEAR, 32'h0, 5'd0, 1'b0);
        rx_hold = 400;
        // three full bursts queue up behind a long hold-off on the result side
        for (int b = 0; b < 3; b++)
            for (int i = 0; i < BURST_MAX; i++)
                send_req(REQ_WRITE, $urandom(), 5'd16, i == 0);
        wait_drain();
        send_req(REQ_PEEK, 32'h0, 5'd16, 1'b0);
        send_req(REQ_READ, 32'h0, 5'd10, 1'b0);
        for (int i = 0; i < 12; i++)
            send_req(REQ_WRITE, $urandom(), 5'd12, i == 0);
        tx_max = 12;
        rx_max = 12;
        for (int i = 0; i < 3; i++)
            send_req(REQ_READ, $urandom(), 5'd16, 1'b0);
        send_req(REQ_READ, 32'h0, 5'd3, 1'b0);
        send_req(REQ_READ, 32'h0, 5'd2, 1'b0);
        wait_drain();
    endtask

    task automatic test_random_traffic();
        int base;
        int pick;
        int blen;
        int cut_at;
        base = req_count;
        while (req_count - base < 90) begin
            if ($urandom_range(11, 0) == 0) begin
                case ($urandom_range(4, 0))
                    0: begin tx_max = 0;  rx_max = 0;  end
                    1: begin tx_max = 12; rx_max = 0;  end
                    2: begin tx_max = 0;  rx_max = 12; end
                    3: begin tx_max = 12; rx_max = 12; end
                    default: begin tx_max = 3; rx_max = 3; end
                endcase
            end
            if ($urandom_range(39, 0) == 0)
                wait_drain();
            pick = $urandom_range(99, 0);
            if (pick < 45) begin
                blen   = $urandom_range(BURST_MAX, 1);
                cut_at = ($urandom_range(9, 0) == 0) ? $urandom_range(blen, 1) : blen;
                for (int i = 0; i < cut_at; i++) begin
                    if (i > 0 && $urandom_range(7, 0) == 0)
                        send_random_read();
                    send_req(REQ_WRITE, $urandom(),
                             (i == 0) ? t_len'(blen) : t_len'($urandom()), i == 0);
                end
            end else if (pick < 85) begin
                send_random_read();
            end else if (pick < 88) begin
                send_req(REQ_CLEAR, $urandom(), t_len'($urandom()), 1'($urandom()));
            end else if (pick < 94) begin
                send_req(REQ_WRITE, $urandom(), t_len'($urandom()), 1'b0);
            end else begin
                send_req(REQ_WRITE, $urandom(),
                         ($urandom_range(1, 0) != 0) ? 5'd0 : t_len'($urandom_range(31, 17)),
                         1'b1);
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_req_type      = REQ_WRITE;
        i_wr_data       = '0;
        i_burst_len     = '0;
        i_burst_first   = 1'b0;
        tx_max          = 0;
        rx_max          = 0;
        rx_hold         = 0;
        mismatches      = 0;
        req_count       = 0;
        wr_idx          = '0;
        rd_idx          = '0;
        fill            = 0;
        burst_remaining = 0;
        burst_dropped   = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_fifo();
        test_write_bursts();
        test_read_peek();
        test_fill_backpressure();
        test_random_traffic();

        wait_drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== word_ring_fifo_burst.f =====
rtl/core/wrf_pkg.sv
rtl/core/wrf_store.sv
rtl/core/word_ring_fifo_burst.sv
test/word_ring_fifo_burst_test.sv
